>>> rtl/core/dovp_pkg.sv
// ----------------------------------------------------------------------------
// dovp_pkg
// Shared request codes for the degree-one vertex peeling block.
// ----------------------------------------------------------------------------
package dovp_pkg;

  localparam int OP_W = 3;

  // Request codes carried on the input tuser field
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_OFF  = 3'd0,
    OP_LOAD_ADJ  = 3'd1,
    OP_RUN       = 3'd2,
    OP_READ_PEEL = 3'd3,
    OP_READ_MAP  = 3'd4,
    OP_READ_ROFF = 3'd5,
    OP_READ_RADJ = 3'd6
  } op_t;

endpackage

>>> rtl/core/dovp_ram.sv
// ----------------------------------------------------------------------------
// dovp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module dovp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write when enabled; read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/degree_one_vertex_peeling.sv
// ----------------------------------------------------------------------------
// degree_one_vertex_peeling
// Loads a CSR graph, peels degree-one vertices toward the 2-core, renumbers
// the survivors and builds a compacted CSR; each request returns a result.
// ----------------------------------------------------------------------------
// Loads and reads: one request per cycle while idle and not back-pressured;
//   each result passes through the pending and output registers.
// Run: computes degrees, pops queued vertices and scans their adjacency
//   entries, renumbers every vertex, then rebuilds the kept rows and their
//   entries; the walk is bound by one read port per state memory.
// Reset clears control state and result totals; memories are not cleared.
// ----------------------------------------------------------------------------
module degree_one_vertex_peeling #(
  parameter int MAX_VERTICES  = 1024,
  parameter int MAX_ADJACENCY = 8192,
  localparam int VW       = $clog2(MAX_VERTICES),
  localparam int CW       = $clog2(MAX_VERTICES + 1),
  localparam int AW       = $clog2(MAX_ADJACENCY),
  localparam int OW       = $clog2(MAX_ADJACENCY + 1),
  localparam int IW       = (OW > CW) ? OW : CW,
  localparam int IN_DW    = ((2 * IW + 7) / 8) * 8,
  localparam int OUT_BITS = 3 * VW + 1 + OW + 2 * CW + AW,
  localparam int OUT_DW   = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration write: vertex_count
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CW-1:0]     cfg_data,
  // request channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // item_index, load_value
  input  logic [2:0]        in_tuser,   // operation
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // vertex_value, neighbor_value, mapped_id,
                                        // offset_value, peeled_total, kept_total,
                                        // reduced_edges
  output logic [0:0]        out_tuser   // index_error
);

  typedef enum logic [4:0] {
    S_IDLE, S_DEG,
    S_P_POP, S_P_V, S_P_S, S_P_E, S_P_ADJ, S_P_W, S_P_WF, S_P_DEC,
    S_M_RD, S_M_WR,
    S_B_RD, S_B_U, S_B_S, S_B_E, S_B_ADJ, S_B_W, S_B_M
  } state_t;

  localparam logic [CW-1:0] MAXV_C = CW'(MAX_VERTICES);
  localparam logic [OW-1:0] MAXA_C = OW'(MAX_ADJACENCY);

  // Clamp a stored row offset to the adjacency store size
  function automatic logic [OW-1:0] clamp_off(input logic [IW-1:0] x);
    logic [OW-1:0] r;
    if (x > IW'(MAX_ADJACENCY)) begin
      r = MAXA_C;
    end else begin
      r = x[OW-1:0];
    end
    return r;
  endfunction

  // Control and working registers
  state_t          state_r, state_nxt;
  logic [CW-1:0]   vcount_r, vcount_nxt;
  logic            p_valid_r, p_valid_nxt;
  dovp_pkg::op_t   p_op_r, p_op_nxt;
  logic            p_err_r, p_err_nxt;
  logic            p_vsel_r, p_vsel_nxt;
  logic [IW-1:0]   p_idx_r, p_idx_nxt;
  logic            o_valid_r, o_valid_nxt;
  logic [OUT_BITS-1:0] out_data_r, out_data_nxt;
  logic            out_err_r, out_err_nxt;
  logic [CW-1:0]   cnt_peeled_r, cnt_peeled_nxt;
  logic [CW-1:0]   cnt_kept_r, cnt_kept_nxt;
  logic [AW-1:0]   cnt_edges_r, cnt_edges_nxt;
  logic [OW-1:0]   cnt_rlen_r, cnt_rlen_nxt;
  logic [CW-1:0]   cnt_n_r, cnt_n_nxt;
  logic [CW-1:0]   n_r, n_nxt;
  logic [CW-1:0]   a_r, a_nxt;
  logic            dv_r, dv_nxt;
  logic [OW-1:0]   prev_r, prev_nxt;
  logic [VW-1:0]   v_r, v_nxt;
  logic [VW-1:0]   w_r, w_nxt;
  logic [OW-1:0]   s_r, s_nxt;
  logic [OW-1:0]   e_r, e_nxt;
  logic [OW-1:0]   k_r, k_nxt;
  logic [VW-1:0]   q_head_r, q_head_nxt;
  logic [VW-1:0]   q_tail_r, q_tail_nxt;
  logic [CW-1:0]   q_fill_r, q_fill_nxt;
  logic [CW-1:0]   peeled_r, peeled_nxt;
  logic [CW-1:0]   kept_r, kept_nxt;
  logic [OW-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]   i_r, i_nxt;

  // Memory ports
  logic            off_we;   logic [CW-1:0] off_waddr, off_raddr;
  logic [IW-1:0]   off_wdata, off_rdata;
  logic            adj_we;   logic [AW-1:0] adj_waddr, adj_raddr;
  logic [VW-1:0]   adj_wdata, adj_rdata;
  logic            deg_we;   logic [VW-1:0] deg_waddr, deg_raddr;
  logic [OW-1:0]   deg_wdata, deg_rdata;
  logic            flg_we;   logic [VW-1:0] flg_waddr, flg_raddr;
  logic            flg_wdata, flg_rdata;
  logic            q_we;     logic [VW-1:0] q_waddr, q_raddr;
  logic [VW-1:0]   q_wdata, q_rdata;
  logic            rec_we;   logic [VW-1:0] rec_waddr, rec_raddr;
  logic [2*VW-1:0] rec_wdata, rec_rdata;
  logic            o2n_we;   logic [VW-1:0] o2n_waddr, o2n_raddr;
  logic [VW:0]     o2n_wdata, o2n_rdata;
  logic            n2o_we;   logic [VW-1:0] n2o_waddr, n2o_raddr;
  logic [VW-1:0]   n2o_wdata, n2o_rdata;
  logic            roff_we;  logic [CW-1:0] roff_waddr, roff_raddr;
  logic [OW-1:0]   roff_wdata, roff_rdata;
  logic            radj_we;  logic [AW-1:0] radj_waddr, radj_raddr;
  logic [VW-1:0]   radj_wdata, radj_rdata;

  // Combinational helpers
  logic            adv;
  logic            in_fire;
  dovp_pkg::op_t   in_op;
  logic [IW-1:0]   in_idx, in_val, rd_idx;
  logic            in_err, in_vsel;
  logic [OW-1:0]   cur_off, deg_val, dec_val, end_off;
  logic [CW-1:0]   deg_vtx;
  logic [VW-1:0]   vv, nv;
  logic [VW:0]     mid;
  logic [OW-1:0]   ov;

  assign cfg_ready  = 1'b1;
  assign in_fire    = in_tvalid & in_tready;
  assign in_op      = dovp_pkg::op_t'(in_tuser);
  assign in_idx     = in_tdata[IW-1:0];
  assign in_val     = in_tdata[2*IW-1:IW];
  assign adv        = !o_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) && (!p_valid_r || adv);
  assign rd_idx     = in_fire ? in_idx : p_idx_r;
  assign out_tvalid = o_valid_r;
  assign out_tdata  = OUT_DW'(out_data_r);
  assign out_tuser  = out_err_r;

  // Classify the incoming request
  always_comb begin
    in_err  = 1'b0;
    in_vsel = 1'b0;
    case (in_op)
      dovp_pkg::OP_LOAD_OFF:  in_err = in_idx > IW'(MAX_VERTICES);
      dovp_pkg::OP_LOAD_ADJ:  in_err = in_idx >= IW'(MAX_ADJACENCY);
      dovp_pkg::OP_READ_PEEL: in_err = in_idx >= IW'(cnt_peeled_r);
      dovp_pkg::OP_READ_MAP: begin
        in_err  = in_idx >= IW'(cnt_n_r);
        in_vsel = in_idx < IW'(cnt_kept_r);
      end
      dovp_pkg::OP_READ_ROFF: in_err = in_idx > IW'(cnt_kept_r);
      dovp_pkg::OP_READ_RADJ: in_err = in_idx >= IW'(cnt_rlen_r);
      default:                in_err = 1'b0;
    endcase
  end

  // Form the result fields from the pending request
  always_comb begin
    vv  = '0;
    nv  = '0;
    mid = '0;
    ov  = '0;
    case (p_op_r)
      dovp_pkg::OP_READ_PEEL: begin
        vv = rec_rdata[VW-1:0];
        nv = rec_rdata[2*VW-1:VW];
      end
      dovp_pkg::OP_READ_MAP: begin
        mid = o2n_rdata;
        if (p_vsel_r) begin
          vv = n2o_rdata;
        end
      end
      dovp_pkg::OP_READ_ROFF: ov = roff_rdata;
      dovp_pkg::OP_READ_RADJ: vv = radj_rdata;
      default: vv = '0;
    endcase
    if (p_err_r) begin
      vv  = '0;
      nv  = '0;
      mid = '0;
      ov  = '0;
    end
  end

  // Next-state, memory control and request pipeline
  always_comb begin
    state_nxt      = state_r;
    vcount_nxt     = vcount_r;
    p_valid_nxt    = p_valid_r;
    p_op_nxt       = p_op_r;
    p_err_nxt      = p_err_r;
    p_vsel_nxt     = p_vsel_r;
    p_idx_nxt      = p_idx_r;
    o_valid_nxt    = o_valid_r;
    out_data_nxt   = out_data_r;
    out_err_nxt    = out_err_r;
    cnt_peeled_nxt = cnt_peeled_r;
    cnt_kept_nxt   = cnt_kept_r;
    cnt_edges_nxt  = cnt_edges_r;
    cnt_rlen_nxt   = cnt_rlen_r;
    cnt_n_nxt      = cnt_n_r;
    n_nxt          = n_r;
    a_nxt          = a_r;
    dv_nxt         = dv_r;
    prev_nxt       = prev_r;
    v_nxt          = v_r;
    w_nxt          = w_r;
    s_nxt          = s_r;
    e_nxt          = e_r;
    k_nxt          = k_r;
    q_head_nxt     = q_head_r;
    q_tail_nxt     = q_tail_r;
    q_fill_nxt     = q_fill_r;
    peeled_nxt     = peeled_r;
    kept_nxt       = kept_r;
    pos_nxt        = pos_r;
    i_nxt          = i_r;

    off_we  = 1'b0; off_waddr  = in_idx[CW-1:0]; off_wdata  = in_val;  off_raddr = a_r;
    adj_we  = 1'b0; adj_waddr  = in_idx[AW-1:0]; adj_wdata  = in_val[VW-1:0];
    adj_raddr = k_r[AW-1:0];
    deg_we  = 1'b0; deg_waddr  = w_r;    deg_wdata  = '0;   deg_raddr = v_r;
    flg_we  = 1'b0; flg_waddr  = v_r;    flg_wdata  = 1'b0; flg_raddr = v_r;
    q_we    = 1'b0; q_waddr    = q_tail_r; q_wdata  = w_r;  q_raddr   = q_head_r;
    rec_we  = 1'b0; rec_waddr  = peeled_r[VW-1:0]; rec_wdata = {w_r, v_r};
    rec_raddr = rd_idx[VW-1:0];
    o2n_we  = 1'b0; o2n_waddr  = i_r[VW-1:0]; o2n_wdata = '1;
    o2n_raddr = rd_idx[VW-1:0];
    n2o_we  = 1'b0; n2o_waddr  = kept_r[VW-1:0]; n2o_wdata = i_r[VW-1:0];
    n2o_raddr = rd_idx[VW-1:0];
    roff_we = 1'b0; roff_waddr = i_r;    roff_wdata = pos_r; roff_raddr = rd_idx[CW-1:0];
    radj_we = 1'b0; radj_waddr = pos_r[AW-1:0]; radj_wdata = '0;
    radj_raddr = rd_idx[AW-1:0];

    cur_off = clamp_off(off_rdata);
    deg_vtx = a_r - CW'(2);
    deg_val = (cur_off > prev_r) ? (cur_off - prev_r) : '0;
    dec_val = (deg_rdata != '0) ? (deg_rdata - 1'b1) : '0;
    end_off = (cur_off < s_r) ? s_r : cur_off;

    // Configuration write
    if (cfg_valid && cfg_ready) begin
      vcount_nxt = cfg_data;
    end

    // Move the pending request into the output register
    if (p_valid_r && adv) begin
      o_valid_nxt  = 1'b1;
      p_valid_nxt  = 1'b0;
      out_data_nxt = {cnt_edges_r, cnt_kept_r, cnt_peeled_r, ov, mid, nv, vv};
      out_err_nxt  = p_err_r;
    end else if (out_tready) begin
      o_valid_nxt = 1'b0;
    end

    // Accept a request
    if (in_fire) begin
      if (in_op == dovp_pkg::OP_RUN) begin
        n_nxt      = (vcount_r > MAXV_C) ? MAXV_C : vcount_r;
        a_nxt      = '0;
        dv_nxt     = 1'b0;
        q_head_nxt = '0;
        q_tail_nxt = '0;
        q_fill_nxt = '0;
        peeled_nxt = '0;
        state_nxt  = S_DEG;
      end else begin
        p_valid_nxt = 1'b1;
        p_op_nxt    = in_op;
        p_err_nxt   = in_err;
        p_vsel_nxt  = in_vsel;
        p_idx_nxt   = in_idx;
        if (in_op == dovp_pkg::OP_LOAD_OFF && !in_err) begin
          off_we = 1'b1;
        end
        if (in_op == dovp_pkg::OP_LOAD_ADJ && !in_err) begin
          adj_we = 1'b1;
        end
      end
    end

    case (state_r)
      S_IDLE: begin
        state_nxt = state_nxt;
      end

      // Stream offsets, write degrees, clear flags, queue degree-one vertices
      S_DEG: begin
        off_raddr = a_r;
        a_nxt     = a_r + 1'b1;
        dv_nxt    = 1'b1;
        if (dv_r) begin
          prev_nxt = cur_off;
          if (a_r != CW'(1)) begin
            deg_we    = 1'b1;
            deg_waddr = deg_vtx[VW-1:0];
            deg_wdata = deg_val;
            flg_we    = 1'b1;
            flg_waddr = deg_vtx[VW-1:0];
            flg_wdata = 1'b0;
            if (deg_val == OW'(1)) begin
              q_we       = 1'b1;
              q_wdata    = deg_vtx[VW-1:0];
              q_tail_nxt = (q_tail_r == VW'(MAX_VERTICES - 1)) ? '0 : q_tail_r + 1'b1;
              q_fill_nxt = q_fill_r + 1'b1;
            end
          end
          if (a_r - 1'b1 == n_r) begin
            dv_nxt    = 1'b0;
            state_nxt = S_P_POP;
          end
        end
      end

      // Pop the next queued vertex
      S_P_POP: begin
        if (q_fill_r == '0) begin
          i_nxt     = '0;
          kept_nxt  = '0;
          state_nxt = S_M_RD;
        end else begin
          q_raddr    = q_head_r;
          q_head_nxt = (q_head_r == VW'(MAX_VERTICES - 1)) ? '0 : q_head_r + 1'b1;
          q_fill_nxt = q_fill_r - 1'b1;
          state_nxt  = S_P_V;
        end
      end

      S_P_V: begin
        v_nxt     = q_rdata;
        flg_raddr = q_rdata;
        deg_raddr = q_rdata;
        off_raddr = CW'(q_rdata);
        state_nxt = S_P_S;
      end

      // Drop vertices already removed or no longer of degree one
      S_P_S: begin
        if (flg_rdata || deg_rdata != OW'(1)) begin
          state_nxt = S_P_POP;
        end else begin
          s_nxt     = cur_off;
          off_raddr = CW'(v_r) + 1'b1;
          state_nxt = S_P_E;
        end
      end

      S_P_E: begin
        e_nxt     = end_off;
        k_nxt     = s_r;
        state_nxt = S_P_ADJ;
      end

      S_P_ADJ: begin
        if (k_r >= e_r) begin
          state_nxt = S_P_POP;
        end else begin
          adj_raddr = k_r[AW-1:0];
          state_nxt = S_P_W;
        end
      end

      S_P_W: begin
        if (CW'(adj_rdata) < n_r) begin
          flg_raddr = adj_rdata;
          w_nxt     = adj_rdata;
          state_nxt = S_P_WF;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_P_ADJ;
        end
      end

      // First live neighbor found: remove the vertex and record the pair
      S_P_WF: begin
        if (!flg_rdata) begin
          flg_we    = 1'b1;
          flg_waddr = v_r;
          flg_wdata = 1'b1;
          if (peeled_r < MAXV_C) begin
            rec_we     = 1'b1;
            peeled_nxt = peeled_r + 1'b1;
          end
          deg_raddr = w_r;
          state_nxt = S_P_DEC;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_P_ADJ;
        end
      end

      // Decrement the neighbor and queue it at degree one
      S_P_DEC: begin
        deg_we    = 1'b1;
        deg_waddr = w_r;
        deg_wdata = dec_val;
        if (dec_val == OW'(1) && q_fill_r < MAXV_C) begin
          q_we       = 1'b1;
          q_wdata    = w_r;
          q_tail_nxt = (q_tail_r == VW'(MAX_VERTICES - 1)) ? '0 : q_tail_r + 1'b1;
          q_fill_nxt = q_fill_r + 1'b1;
        end
        state_nxt = S_P_POP;
      end

      // Renumber survivors in ascending order
      S_M_RD: begin
        if (i_r == n_r) begin
          i_nxt     = '0;
          pos_nxt   = '0;
          state_nxt = S_B_RD;
        end else begin
          flg_raddr = i_r[VW-1:0];
          state_nxt = S_M_WR;
        end
      end

      S_M_WR: begin
        o2n_we    = 1'b1;
        o2n_waddr = i_r[VW-1:0];
        if (flg_rdata) begin
          o2n_wdata = '1;
        end else begin
          o2n_wdata = {1'b0, kept_r[VW-1:0]};
          n2o_we    = 1'b1;
          kept_nxt  = kept_r + 1'b1;
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = S_M_RD;
      end

      // Write the row start; finish after the closing offset
      S_B_RD: begin
        roff_we    = 1'b1;
        roff_waddr = i_r;
        if (i_r == kept_r) begin
          cnt_peeled_nxt = peeled_r;
          cnt_kept_nxt   = kept_r;
          cnt_edges_nxt  = AW'(pos_r >> 1);
          cnt_rlen_nxt   = pos_r;
          cnt_n_nxt      = n_r;
          p_valid_nxt    = 1'b1;
          p_op_nxt       = dovp_pkg::OP_RUN;
          p_err_nxt      = 1'b0;
          p_vsel_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end else begin
          n2o_raddr = i_r[VW-1:0];
          state_nxt = S_B_U;
        end
      end

      S_B_U: begin
        v_nxt     = n2o_rdata;
        off_raddr = CW'(n2o_rdata);
        state_nxt = S_B_S;
      end

      S_B_S: begin
        s_nxt     = cur_off;
        off_raddr = CW'(v_r) + 1'b1;
        state_nxt = S_B_E;
      end

      S_B_E: begin
        e_nxt     = end_off;
        k_nxt     = s_r;
        state_nxt = S_B_ADJ;
      end

      S_B_ADJ: begin
        if (k_r >= e_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_B_RD;
        end else begin
          adj_raddr = k_r[AW-1:0];
          state_nxt = S_B_W;
        end
      end

      S_B_W: begin
        if (CW'(adj_rdata) < n_r) begin
          o2n_raddr = adj_rdata;
          state_nxt = S_B_M;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_B_ADJ;
        end
      end

      // Copy live entries under their new ids, dropping overflow
      S_B_M: begin
        if (!o2n_rdata[VW] && pos_r < MAXA_C) begin
          radj_we    = 1'b1;
          radj_waddr = pos_r[AW-1:0];
          radj_wdata = o2n_rdata[VW-1:0];
          pos_nxt    = pos_r + 1'b1;
        end
        k_nxt     = k_r + 1'b1;
        state_nxt = S_B_ADJ;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State, control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      vcount_r     <= '0;
      p_valid_r    <= 1'b0;
      o_valid_r    <= 1'b0;
      cnt_peeled_r <= '0;
      cnt_kept_r   <= '0;
      cnt_edges_r  <= '0;
      cnt_rlen_r   <= '0;
      cnt_n_r      <= '0;
      dv_r         <= 1'b0;
      q_head_r     <= '0;
      q_tail_r     <= '0;
      q_fill_r     <= '0;
      peeled_r     <= '0;
      kept_r       <= '0;
      pos_r        <= '0;
      n_r          <= '0;
    end else begin
      state_r      <= state_nxt;
      vcount_r     <= vcount_nxt;
      p_valid_r    <= p_valid_nxt;
      o_valid_r    <= o_valid_nxt;
      cnt_peeled_r <= cnt_peeled_nxt;
      cnt_kept_r   <= cnt_kept_nxt;
      cnt_edges_r  <= cnt_edges_nxt;
      cnt_rlen_r   <= cnt_rlen_nxt;
      cnt_n_r      <= cnt_n_nxt;
      dv_r         <= dv_nxt;
      q_head_r     <= q_head_nxt;
      q_tail_r     <= q_tail_nxt;
      q_fill_r     <= q_fill_nxt;
      peeled_r     <= peeled_nxt;
      kept_r       <= kept_nxt;
      pos_r        <= pos_nxt;
      n_r          <= n_nxt;
    end
    p_op_r     <= p_op_nxt;
    p_err_r    <= p_err_nxt;
    p_vsel_r   <= p_vsel_nxt;
    p_idx_r    <= p_idx_nxt;
    out_data_r <= out_data_nxt;
    out_err_r  <= out_err_nxt;
    a_r        <= a_nxt;
    prev_r     <= prev_nxt;
    v_r        <= v_nxt;
    w_r        <= w_nxt;
    s_r        <= s_nxt;
    e_r        <= e_nxt;
    k_r        <= k_nxt;
    i_r        <= i_nxt;
  end

  // State memories
  dovp_ram #(.WIDTH(IW), .DEPTH(MAX_VERTICES + 1)) u_off (
    .clk(clk), .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
    .raddr(off_raddr), .rdata(off_rdata));
  dovp_ram #(.WIDTH(VW), .DEPTH(MAX_ADJACENCY)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_rdata));
  dovp_ram #(.WIDTH(OW), .DEPTH(MAX_VERTICES)) u_deg (
    .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
    .raddr(deg_raddr), .rdata(deg_rdata));
  dovp_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_flg (
    .clk(clk), .we(flg_we), .waddr(flg_waddr), .wdata(flg_wdata),
    .raddr(flg_raddr), .rdata(flg_rdata));
  dovp_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata));
  dovp_ram #(.WIDTH(2 * VW), .DEPTH(MAX_VERTICES)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(rec_raddr), .rdata(rec_rdata));
  dovp_ram #(.WIDTH(VW + 1), .DEPTH(MAX_VERTICES)) u_o2n (
    .clk(clk), .we(o2n_we), .waddr(o2n_waddr), .wdata(o2n_wdata),
    .raddr(o2n_raddr), .rdata(o2n_rdata));
  dovp_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_n2o (
    .clk(clk), .we(n2o_we), .waddr(n2o_waddr), .wdata(n2o_wdata),
    .raddr(n2o_raddr), .rdata(n2o_rdata));
  dovp_ram #(.WIDTH(OW), .DEPTH(MAX_VERTICES + 1)) u_roff (
    .clk(clk), .we(roff_we), .waddr(roff_waddr), .wdata(roff_wdata),
    .raddr(roff_raddr), .rdata(roff_rdata));
  dovp_ram #(.WIDTH(VW), .DEPTH(MAX_ADJACENCY)) u_radj (
    .clk(clk), .we(radj_we), .waddr(radj_waddr), .wdata(radj_wdata),
    .raddr(radj_raddr), .rdata(radj_rdata));

  // Queue never overfills
  a_qfill: assert property (@(posedge clk) disable iff (!rst_n)
    q_fill_r <= MAXV_C)
    else $error("work queue fill out of range");

  // No request result is pending while a run walks the graph
  a_run_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !p_valid_r)
    else $error("pending request during run");

  // Reduced adjacency length stays within the store
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= MAXA_C)
    else $error("reduced adjacency overflow");

  // Every vertex of the last run is either peeled or kept
  a_totals: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |->
      ({1'b0, cnt_peeled_r} + {1'b0, cnt_kept_r}) == {1'b0, cnt_n_r})
    else $error("peeled and kept totals disagree with vertex count");

endmodule
